### sv/heap_page_sweep_coalescer_core_assert.svh
// Assertion macros for the sweep coalescer command queue.
// Each macro takes a label, an antecedent and a consequent, and is checked
// at the rising edge of clk while rst_n is high.
`ifndef HEAP_PAGE_SWEEP_COALESCER_CORE_ASSERT_SVH
`define HEAP_PAGE_SWEEP_COALESCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HPSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpsc: same-cycle check failed");
`define HPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpsc: next-cycle check failed");
`else
`define HPSC_ASSERT_NOW(lbl, ante, cons)
`define HPSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/hpsc_pkg.sv
package hpsc_pkg;

  // Width of the internal address space; the cursor saturates at its top.
  localparam int ADDR_BITS  = 48;
  // Fixed field widths of the ports.
  localparam int FIELD_W    = 48;
  localparam int REGION_W   = 32;
  localparam int SIZE_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int KIND_W     = 2;

  // Object sizes are rounded up to a power-of-two alignment.
  localparam int ALIGN_LOG2  = 3;
  localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;
  localparam int RSIZE_W     = SIZE_W + 1;

  localparam logic [ADDR_BITS-1:0] ADDR_MAX  = {ADDR_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_FINALIZE_EN = 3'd0;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_OBJECT = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FREE     = 2'd0,
    KIND_FINALIZE = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_t;

  // One queued command: up to three result words, always sent in the
  // order finalize, free block, summary.
  typedef struct packed {
    logic                 fin;
    logic                 free;
    logic                 sum;
    logic [ADDR_BITS-1:0] fin_addr;
    logic [ADDR_BITS-1:0] free_addr;
    logic [ADDR_BITS-1:0] free_len;
    logic [ADDR_BITS-1:0] sum_base;
    logic [ADDR_BITS-1:0] sum_reclaimed;
    logic [ADDR_BITS-1:0] sum_live;
    logic [ADDR_BITS-1:0] sum_span;
    logic [REGION_W-1:0]  sum_region;
    logic [COUNT_W-1:0]   sum_count;
  } entry_t;

endpackage

### sv/heap_page_sweep_coalescer_core.sv
// Heap page sweep coalescer.
// Input words arrive through push/full: a start word opens a page (start,
// limit, region id) and each object word gives the size and mark bit of the
// object at the sweep cursor. Results leave through empty/pop, oldest first:
// finalize requests, coalesced free blocks and one summary per closed page.
// The last flag marks the final result word caused by one input word.
// One input word is accepted per cycle while the command queue has room;
// the page state is updated in that same cycle. The results of a word pass
// through the command queue into the result register. While the receiver pops,
// the result side delivers one word per cycle, so input words with two or three
// results drain at that rate and the four-entry queue absorbs the difference.
// When the receiver holds pop low, the queue fills and full rises; the
// front then waits, and nothing is lost or reordered.
// Reset clears the page state, empties the queue and sets finalize_enable.
// The configuration port holds one register, finalize_enable at byte
// address 0, to be written only while the block is idle.
module heap_page_sweep_coalescer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_opcode,
  input  logic [hpsc_pkg::FIELD_W-1:0]      in_page_start,
  input  logic [hpsc_pkg::FIELD_W-1:0]      in_page_limit,
  input  logic [hpsc_pkg::REGION_W-1:0]     in_region_id,
  input  logic [hpsc_pkg::SIZE_W-1:0]       in_obj_size,
  input  logic                              in_marked,
  output logic                              empty,
  input  logic                              pop,
  output logic [hpsc_pkg::KIND_W-1:0]       out_kind,
  output logic [hpsc_pkg::FIELD_W-1:0]      out_address,
  output logic [hpsc_pkg::FIELD_W-1:0]      out_length,
  output logic [hpsc_pkg::REGION_W-1:0]     out_region_out,
  output logic [hpsc_pkg::FIELD_W-1:0]      out_live_total,
  output logic [hpsc_pkg::FIELD_W-1:0]      out_free_total,
  output logic [hpsc_pkg::COUNT_W-1:0]      out_live_count,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hpsc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hpsc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import hpsc_pkg::*;

  logic   fin_en_r, fin_en_nxt;
  logic   cfg_write;
  logic   in_take;
  logic   q_wr_en;
  entry_t q_wr_data;
  logic   q_rd_en;
  entry_t q_head;
  logic   q_empty;

  // The configuration port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    fin_en_nxt = fin_en_r;
    if (cfg_write && (paddr == REG_FINALIZE_EN)) begin
      fin_en_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_en_r <= 1'b1;
    end else begin
      fin_en_r <= fin_en_nxt;
    end
  end

  assign prdata = (paddr == REG_FINALIZE_EN) ? CFG_DATA_W'(fin_en_r) : '0;

  // An input word is taken whenever the queue has room.
  assign in_take = push && !full;

  hpsc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_take),
    .finalize_enable (fin_en_r),
    .opcode          (in_opcode),
    .page_start      (in_page_start),
    .page_limit      (in_page_limit),
    .region_id       (in_region_id),
    .obj_size        (in_obj_size),
    .marked          (in_marked),
    .wr_en           (q_wr_en),
    .wr_data         (q_wr_data)
  );

  hpsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_head),
    .q_empty (q_empty),
    .full    (full)
  );

  hpsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .rd_en      (q_rd_en),
    .pop        (pop),
    .empty      (empty),
    .kind       (out_kind),
    .address    (out_address),
    .length     (out_length),
    .region_out (out_region_out),
    .live_total (out_live_total),
    .free_total (out_free_total),
    .live_count (out_live_count),
    .last       (out_last)
  );

endmodule

### sv/hpsc_queue.sv
`include "heap_page_sweep_coalescer_core_assert.svh"

module hpsc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  hpsc_pkg::entry_t wr_data,
  input  logic            rd_en,
  output hpsc_pkg::entry_t rd_data,
  output logic            q_empty,
  output logic            full
);
  import hpsc_pkg::*;

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign q_empty = (count_r == '0);
  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));

  `HPSC_ASSERT_NOW(a_no_overrun, wr_en, !full)
  `HPSC_ASSERT_NOW(a_no_underrun, rd_en, !q_empty)
  `HPSC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= Q_CNT_W'(Q_DEPTH))
  `HPSC_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_r == $past(count_r) + 1'b1)

endmodule

### sv/hpsc_front.sv
module hpsc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           finalize_enable,
  input  logic                           opcode,
  input  logic [hpsc_pkg::FIELD_W-1:0]   page_start,
  input  logic [hpsc_pkg::FIELD_W-1:0]   page_limit,
  input  logic [hpsc_pkg::REGION_W-1:0]  region_id,
  input  logic [hpsc_pkg::SIZE_W-1:0]    obj_size,
  input  logic                           marked,
  output logic                           wr_en,
  output hpsc_pkg::entry_t               wr_data
);
  import hpsc_pkg::*;

  logic                 open_r, open_nxt;
  logic [ADDR_BITS-1:0] cursor_r, cursor_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] top_r, top_nxt;
  logic [ADDR_BITS-1:0] span_r, span_nxt;
  logic [REGION_W-1:0]  region_r, region_nxt;
  logic [ADDR_BITS-1:0] run_start_r, run_start_nxt;
  logic [ADDR_BITS-1:0] run_bytes_r, run_bytes_nxt;
  logic [ADDR_BITS-1:0] live_r, live_nxt;
  logic [ADDR_BITS-1:0] recl_r, recl_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;

  logic [RSIZE_W-1:0]   size_rnd;
  logic [ADDR_BITS-1:0] size_ext;
  logic [ADDR_BITS-1:0] start_in;
  logic [ADDR_BITS-1:0] limit_in;
  logic [ADDR_BITS:0]   cur_sum;
  logic                 close_now;
  entry_t               ent;

  function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_W-1:0] s);
    logic [RSIZE_W-1:0] t;
    t = {1'b0, s} + RSIZE_W'(ALIGN_BYTES - 1);
    return t & ~RSIZE_W'(ALIGN_BYTES - 1);
  endfunction

  function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                   input logic [ADDR_BITS-1:0] b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? ADDR_MAX : s[ADDR_BITS-1:0];
  endfunction

  always_comb begin
    size_rnd = round_size(obj_size);
    size_ext = ADDR_BITS'(size_rnd);
    start_in = ADDR_BITS'(page_start);
    limit_in = ADDR_BITS'(page_limit);
    cur_sum  = {1'b0, cursor_r} + {1'b0, size_ext};

    open_nxt      = open_r;
    cursor_nxt    = cursor_r;
    base_nxt      = base_r;
    top_nxt       = top_r;
    span_nxt      = span_r;
    region_nxt    = region_r;
    run_start_nxt = run_start_r;
    run_bytes_nxt = run_bytes_r;
    live_nxt      = live_r;
    recl_nxt      = recl_r;
    count_nxt     = count_r;
    close_now     = 1'b0;
    ent           = '0;

    if (accept) begin
      if (opcode == OP_START) begin
        base_nxt      = start_in;
        top_nxt       = limit_in;
        span_nxt      = (limit_in > start_in) ? limit_in - start_in : '0;
        region_nxt    = region_id;
        cursor_nxt    = start_in;
        run_start_nxt = '0;
        run_bytes_nxt = '0;
        live_nxt      = '0;
        recl_nxt      = '0;
        count_nxt     = '0;
        open_nxt      = 1'b1;
        close_now     = !(start_in < limit_in);
      end else if (open_r) begin
        if (obj_size == '0) begin
          close_now = 1'b1;
        end else begin
          if (marked) begin
            // A live object ends the pending free run.
            if (run_bytes_r != '0) begin
              ent.free      = 1'b1;
              ent.free_addr = run_start_r;
              ent.free_len  = run_bytes_r;
            end
            run_bytes_nxt = '0;
            live_nxt      = sat_add(live_r, size_ext);
            count_nxt     = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
          end else begin
            ent.fin      = finalize_enable;
            ent.fin_addr = cursor_r;
            if (run_bytes_r == '0) begin
              run_start_nxt = cursor_r;
            end
            run_bytes_nxt = sat_add(run_bytes_r, size_ext);
            recl_nxt      = sat_add(recl_r, size_ext);
          end
          if (cur_sum[ADDR_BITS]) begin
            cursor_nxt = ADDR_MAX;
            close_now  = 1'b1;
          end else begin
            cursor_nxt = cur_sum[ADDR_BITS-1:0];
            close_now  = (cur_sum[ADDR_BITS-1:0] >= top_r);
          end
        end
      end

      if (close_now) begin
        // On close a live object has already flushed, so at most one free
        // block can come from one item.
        if (run_bytes_nxt != '0) begin
          ent.free      = 1'b1;
          ent.free_addr = run_start_nxt;
          ent.free_len  = run_bytes_nxt;
        end
        run_bytes_nxt     = '0;
        ent.sum           = 1'b1;
        ent.sum_base      = base_nxt;
        ent.sum_reclaimed = recl_nxt;
        ent.sum_live      = live_nxt;
        ent.sum_span      = span_nxt;
        ent.sum_region    = region_nxt;
        ent.sum_count     = count_nxt;
        open_nxt          = 1'b0;
      end
    end
  end

  assign wr_en   = accept && (ent.fin || ent.free || ent.sum);
  assign wr_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      cursor_r    <= '0;
      base_r      <= '0;
      top_r       <= '0;
      span_r      <= '0;
      region_r    <= '0;
      run_start_r <= '0;
      run_bytes_r <= '0;
      live_r      <= '0;
      recl_r      <= '0;
      count_r     <= '0;
    end else begin
      open_r      <= open_nxt;
      cursor_r    <= cursor_nxt;
      base_r      <= base_nxt;
      top_r       <= top_nxt;
      span_r      <= span_nxt;
      region_r    <= region_nxt;
      run_start_r <= run_start_nxt;
      run_bytes_r <= run_bytes_nxt;
      live_r      <= live_nxt;
      recl_r      <= recl_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

### sv/hpsc_back.sv
module hpsc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hpsc_pkg::entry_t               q_head,
  input  logic                           q_empty,
  output logic                           rd_en,
  input  logic                           pop,
  output logic                           empty,
  output logic [hpsc_pkg::KIND_W-1:0]    kind,
  output logic [hpsc_pkg::FIELD_W-1:0]   address,
  output logic [hpsc_pkg::FIELD_W-1:0]   length,
  output logic [hpsc_pkg::REGION_W-1:0]  region_out,
  output logic [hpsc_pkg::FIELD_W-1:0]   live_total,
  output logic [hpsc_pkg::FIELD_W-1:0]   free_total,
  output logic [hpsc_pkg::COUNT_W-1:0]   live_count,
  output logic                           last
);
  import hpsc_pkg::*;

  // Pending words of the held command: bit 0 finalize, 1 free, 2 summary.
  logic [2:0]           pend_r, pend_nxt;
  logic [2:0]           pend_after;
  entry_t               cur_r, cur_nxt;
  logic                 pop_ok;
  logic [ADDR_BITS-1:0] free_bytes;

  always_comb begin
    pop_ok     = pop && (pend_r != '0);
    pend_after = pend_r;
    if (pop_ok) begin
      priority if (pend_r[0]) begin
        pend_after[0] = 1'b0;
      end else if (pend_r[1]) begin
        pend_after[1] = 1'b0;
      end else begin
        pend_after[2] = 1'b0;
      end
    end
    rd_en    = !q_empty && (pend_after == '0);
    pend_nxt = rd_en ? {q_head.sum, q_head.free, q_head.fin} : pend_after;
    cur_nxt  = rd_en ? q_head : cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign free_bytes = (cur_r.sum_span > cur_r.sum_live) ?
                      cur_r.sum_span - cur_r.sum_live : '0;

  always_comb begin
    kind       = KIND_SUMMARY;
    address    = '0;
    length     = '0;
    region_out = '0;
    live_total = '0;
    free_total = '0;
    live_count = '0;
    priority if (pend_r[0]) begin
      kind    = KIND_FINALIZE;
      address = FIELD_W'(cur_r.fin_addr);
    end else if (pend_r[1]) begin
      kind    = KIND_FREE;
      address = FIELD_W'(cur_r.free_addr);
      length  = FIELD_W'(cur_r.free_len);
    end else begin
      kind       = KIND_SUMMARY;
      address    = FIELD_W'(cur_r.sum_base);
      length     = FIELD_W'(cur_r.sum_reclaimed);
      region_out = cur_r.sum_region;
      live_total = FIELD_W'(cur_r.sum_live);
      free_total = FIELD_W'(free_bytes);
      live_count = cur_r.sum_count;
    end
  end

  assign empty = (pend_r == '0);
  assign last  = (pend_r != '0) && ((pend_r & (pend_r - 3'd1)) == '0);

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the heap page sweep coalescer.
// Input words go in through push/full and result words come out through
// empty/pop. A behavioral copy of the sweep (page state, free run, totals)
// runs alongside the block. Every accepted input word is applied to it, and
// the result words it owes go into a queue. Each popped word is then
// compared, field by field, with the head of that queue.
module tb;
  import hpsc_pkg::*;

  // Longest stretch with no word accepted on either side before the run is
  // declared hung. The slowest correct stretch is the long pop hold-off or a
  // capped sender gap, both well under the limit.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 64;
  // A word with no result may still be in flight when the queue runs dry,
  // so let it settle.
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_GAP        = 60;
  localparam int PHASE_WORDS    = 47;

  typedef struct packed {
    op_t                 op;
    logic [FIELD_W-1:0]  pg_start;
    logic [FIELD_W-1:0]  pg_limit;
    logic [REGION_W-1:0] region;
    logic [SIZE_W-1:0]   size;
    logic                marked;
  } sweep_word_t;

  typedef struct packed {
    kind_t               kind;
    logic [FIELD_W-1:0]  addr;
    logic [FIELD_W-1:0]  len;
    logic [REGION_W-1:0] region;
    logic [FIELD_W-1:0]  live;
    logic [FIELD_W-1:0]  freeb;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } sweep_result_t;

  // A row of the directed table. Rows whose outcome is plain to see carry
  // the result word typed in; all others are judged by the sweep copy.
  typedef struct packed {
    sweep_word_t   w;
    logic          typed;
    logic          has_res;
    sweep_result_t res;
  } sweep_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  logic                  in_opcode = 1'b0;
  logic [FIELD_W-1:0]    in_page_start = '0;
  logic [FIELD_W-1:0]    in_page_limit = '0;
  logic [REGION_W-1:0]   in_region_id  = '0;
  logic [SIZE_W-1:0]     in_obj_size   = '0;
  logic                  in_marked     = 1'b0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [FIELD_W-1:0]    out_address;
  logic [FIELD_W-1:0]    out_length;
  logic [REGION_W-1:0]   out_region_out;
  logic [FIELD_W-1:0]    out_live_total;
  logic [FIELD_W-1:0]    out_free_total;
  logic [COUNT_W-1:0]    out_live_count;
  logic                  out_last;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  heap_page_sweep_coalescer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_opcode(in_opcode), .in_page_start(in_page_start),
    .in_page_limit(in_page_limit), .in_region_id(in_region_id),
    .in_obj_size(in_obj_size), .in_marked(in_marked),
    .empty(empty), .pop(pop),
    .out_kind(out_kind), .out_address(out_address), .out_length(out_length),
    .out_region_out(out_region_out), .out_live_total(out_live_total),
    .out_free_total(out_free_total), .out_live_count(out_live_count),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sweep copy: configuration and page state at the block's widths.
  logic                sw_fin_en;
  logic                sw_open;
  logic [FIELD_W-1:0]  sw_cursor, sw_base, sw_top;
  logic [REGION_W-1:0] sw_region;
  logic [FIELD_W-1:0]  sw_run_at, sw_run_len, sw_live_acc, sw_reclaimed;
  logic [COUNT_W-1:0]  sw_nlive;

  // Result words owed by the word just applied, then those still due.
  sweep_result_t owed [3];
  int            n_owed;
  sweep_result_t sweep_results_due [$];

  sweep_row_t    dir_rows [$];
  sweep_result_t head_word;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_go        = 1'b0;
  logic hold_pop      = 1'b0;
  int  mismatches     = 0;
  int  sent_words     = 0;
  int  ignored_words  = 0;
  int  kind_tally [3] = '{0, 0, 0};

  function automatic logic [FIELD_W-1:0] add_clamped(input logic [FIELD_W-1:0] a,
                                                     input logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'(ADDR_MAX)) ? ADDR_MAX : s[FIELD_W-1:0];
  endfunction

  task automatic owe_word(input kind_t k, input logic [FIELD_W-1:0] addr,
                          input logic [FIELD_W-1:0] len,
                          input logic [REGION_W-1:0] region,
                          input logic [FIELD_W-1:0] live,
                          input logic [FIELD_W-1:0] freeb,
                          input logic [COUNT_W-1:0] count);
    owed[n_owed].kind   = k;
    owed[n_owed].addr   = addr;
    owed[n_owed].len    = len;
    owed[n_owed].region = region;
    owed[n_owed].live   = live;
    owed[n_owed].freeb  = freeb;
    owed[n_owed].count  = count;
    owed[n_owed].last   = 1'b0;
    n_owed++;
  endtask

  task automatic flush_free_run();
    if (sw_run_len != '0) begin
      owe_word(KIND_FREE, sw_run_at, sw_run_len, '0, '0, '0, '0);
      sw_run_len = '0;
    end
  endtask

  // Closing a page flushes the trailing run, then reports the totals. The
  // free total is the span less the live bytes and never goes below zero.
  task automatic close_sweep_page();
    logic [FIELD_W-1:0] span;
    logic [FIELD_W-1:0] freeb;
    flush_free_run();
    span  = (sw_top > sw_base) ? sw_top - sw_base : '0;
    freeb = (span > sw_live_acc) ? span - sw_live_acc : '0;
    owe_word(KIND_SUMMARY, sw_base, sw_reclaimed, sw_region, sw_live_acc, freeb,
             sw_nlive);
    sw_open = 1'b0;
  endtask

  task automatic sweep_reset();
    sw_fin_en    = 1'b1;
    sw_open      = 1'b0;
    sw_cursor    = '0;
    sw_base      = '0;
    sw_top       = '0;
    sw_region    = '0;
    sw_run_at    = '0;
    sw_run_len   = '0;
    sw_live_acc  = '0;
    sw_reclaimed = '0;
    sw_nlive     = '0;
  endtask

  // Applies one accepted input word and leaves the result words it causes
  // in owed[0 .. n_owed-1], the final one flagged last.
  task automatic sweep_apply(input sweep_word_t w);
    logic [63:0] rsize;
    logic [63:0] next;
    n_owed = 0;
    if (w.op == OP_START) begin
      // A start while a page is open simply drops the old page.
      sw_base      = w.pg_start;
      sw_top       = w.pg_limit;
      sw_region    = w.region;
      sw_cursor    = w.pg_start;
      sw_run_at    = '0;
      sw_run_len   = '0;
      sw_live_acc  = '0;
      sw_reclaimed = '0;
      sw_nlive     = '0;
      sw_open      = 1'b1;
      if (sw_cursor >= sw_top) close_sweep_page();
    end else if (sw_open) begin
      if (w.size == '0) begin
        close_sweep_page();
      end else begin
        rsize = (64'(w.size) + 64'(ALIGN_BYTES - 1)) & ~64'(ALIGN_BYTES - 1);
        if (w.marked) begin
          flush_free_run();
          sw_live_acc = add_clamped(sw_live_acc, rsize);
          if (sw_nlive != COUNT_MAX) sw_nlive = sw_nlive + 1'b1;
        end else begin
          if (sw_fin_en) owe_word(KIND_FINALIZE, sw_cursor, '0, '0, '0, '0, '0);
          if (sw_run_len == '0) sw_run_at = sw_cursor;
          sw_run_len   = add_clamped(sw_run_len, rsize);
          sw_reclaimed = add_clamped(sw_reclaimed, rsize);
        end
        // Running off the top of the address space pins the cursor there
        // and ends the page.
        next = 64'(sw_cursor) + rsize;
        if (next > 64'(ADDR_MAX)) begin
          sw_cursor = ADDR_MAX;
          close_sweep_page();
        end else begin
          sw_cursor = next[FIELD_W-1:0];
          if (sw_cursor >= sw_top) close_sweep_page();
        end
      end
    end
    if (n_owed > 0) owed[n_owed-1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: check the word taken at this edge, then decide whether to
  // pop in the next cycle. The long hold-off overrides the random stall.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (sweep_results_due.size() == 0) begin
        $error("result word of kind %0d with nothing due", out_kind);
        mismatches++;
      end else begin
        head_word = sweep_results_due.pop_front();
        check_field("kind", 64'(head_word.kind), 64'(out_kind));
        check_field("address", 64'(head_word.addr), 64'(out_address));
        check_field("length", 64'(head_word.len), 64'(out_length));
        check_field("region_out", 64'(head_word.region), 64'(out_region_out));
        check_field("live_total", 64'(head_word.live), 64'(out_live_total));
        check_field("free_total", 64'(head_word.freeb), 64'(out_free_total));
        check_field("live_count", 64'(head_word.count), 64'(out_live_count));
        check_field("last", 64'(head_word.last), 64'(out_last));
        kind_tally[head_word.kind]++;
      end
    end
    pop <= !hold_pop && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here while the sender keeps offering
  // words, so the command queue fills and full has to rise.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word accepted for %0d cycles, %0d result words still due",
             WATCHDOG_LIMIT, sweep_results_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Appends one result word to the tail of the due queue.
  task automatic add_due(input sweep_result_t r);
    sweep_results_due.insert(sweep_results_due.size(), r);
  endtask

  // Offers one word and holds it until the block takes it. Typed rows queue
  // their own result word; the sweep copy still runs to track the page.
  task automatic send_word(input sweep_word_t w, input logic typed,
                           input logic has_res, input sweep_result_t res);
    int gap;
    int i;
    in_opcode     <= w.op;
    in_page_start <= w.pg_start;
    in_page_limit <= w.pg_limit;
    in_region_id  <= w.region;
    in_obj_size   <= w.size;
    in_marked     <= w.marked;
    push          <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    if (w.op == OP_OBJECT && !sw_open) ignored_words++;
    else sent_words++;
    sweep_apply(w);
    if (typed) begin
      if (has_res) add_due(res);
    end else begin
      for (i = 0; i < n_owed; i++) add_due(owed[i]);
    end
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every owed result word has come out, then lets the block
  // settle so that nothing is in flight.
  task automatic drain_results();
    push <= 1'b0;
    while (sweep_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FINALIZE_EN;
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sw_fin_en = v;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_FINALIZE_EN;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field("finalize_enable", 64'(want), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FIELD_W-1:0];
  endfunction

  function automatic sweep_row_t start_row(input logic [FIELD_W-1:0] b,
                                           input logic [FIELD_W-1:0] l,
                                           input logic [REGION_W-1:0] r);
    sweep_row_t x;
    x = '0;
    x.w.op       = OP_START;
    x.w.pg_start = b;
    x.w.pg_limit = l;
    x.w.region   = r;
    return x;
  endfunction

  function automatic sweep_row_t obj_row(input logic [SIZE_W-1:0] s, input logic m);
    sweep_row_t x;
    x = '0;
    x.w.op     = OP_OBJECT;
    x.w.size   = s;
    x.w.marked = m;
    return x;
  endfunction

  function automatic sweep_result_t lone_word(input kind_t k,
                                              input logic [FIELD_W-1:0] addr,
                                              input logic [REGION_W-1:0] region);
    sweep_result_t x;
    x = '0;
    x.kind   = k;
    x.addr   = addr;
    x.region = region;
    x.last   = 1'b1;
    return x;
  endfunction

  function automatic sweep_row_t typed_as(input sweep_row_t x, input logic has,
                                          input sweep_result_t res);
    x.typed   = 1'b1;
    x.has_res = has;
    x.res     = res;
    return x;
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input sweep_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Random words are mostly well-formed pages: a start with a short span
  // followed by small objects. Mixed in are pages near the top of the
  // address space, limits below the start, zero sizes, huge sizes, starts
  // that drop an open page and objects with no page open.
  function automatic sweep_word_t random_word();
    sweep_word_t w;
    int pick;
    int shape;
    w.op       = OP_OBJECT;
    w.pg_start = rand48();
    w.pg_limit = rand48();
    w.region   = $urandom;
    w.size     = $urandom;
    w.marked   = 1'($urandom_range(1));
    pick       = $urandom_range(99);
    if (sw_open ? pick < 6 : pick >= 10) begin
      w.op  = OP_START;
      shape = $urandom_range(99);
      if (shape < 8) w.pg_start = ADDR_MAX - FIELD_W'($urandom_range(300));
      else if (shape < 70) w.pg_start[2:0] = 3'b000;
      if (shape < 8 || shape >= 14)
        w.pg_limit = w.pg_start + FIELD_W'($urandom_range(400));
    end else if (sw_open && pick >= 15) begin
      w.size = (pick < 20) ? '0 : SIZE_W'($urandom_range(64, 1));
    end
    return w;
  endfunction

  initial begin
    int ph;
    int goal;
    sweep_row_t row;
    sweep_result_t none;

    none = '0;
    sweep_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Finalize requests are on out of reset.
    cfg_read_check(1'b1);

    // Directed table: objects with no page open, empty pages at both ends of
    // the address space, rounding of odd sizes, coalescing of dead runs,
    // a start that drops an open page, three results from one word, live
    // bytes past the span, and a cursor running off the address space.
    add_row(typed_as(obj_row(32'd16, 1'b1), 1'b0, none));
    add_row(typed_as(start_row('0, '0, '0), 1'b1,
                     lone_word(KIND_SUMMARY, '0, '0)));
    add_row(typed_as(start_row(ADDR_MAX, '0, '1), 1'b1,
                     lone_word(KIND_SUMMARY, ADDR_MAX, '1)));
    add_row(start_row(48'h1000, 48'h1100, 32'h55));
    add_row(typed_as(obj_row(32'd1, 1'b0), 1'b1,
                     lone_word(KIND_FINALIZE, 48'h1000, '0)));
    add_row(obj_row(32'd9, 1'b0));
    add_row(obj_row(32'd8, 1'b1));
    add_row(obj_row(32'd0, 1'b0));
    add_row(start_row(48'h2000, 48'h2040, 32'h7));
    add_row(obj_row(32'd32, 1'b0));
    add_row(start_row(48'h3000, 48'h3030, 32'h9));
    add_row(obj_row(32'd16, 1'b1));
    add_row(obj_row(32'd24, 1'b0));
    add_row(start_row(48'h4000, 48'h4010, 32'h4));
    add_row(obj_row(32'hFFFF_FFFF, 1'b1));
    add_row(start_row(ADDR_MAX - 48'd15, ADDR_MAX, 32'hA5A5_A5A5));
    add_row(obj_row(32'd8, 1'b0));
    add_row(obj_row(32'hFFFF_FFFF, 1'b0));
    add_row(typed_as(obj_row(32'd8, 1'b0), 1'b0, none));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.w, row.typed, row.has_res, row.res);
    end
    drain_results();

    // Random phases: no idling (with the long pop hold-off), a mostly idle
    // sender, a mostly stalled receiver, then light idling on both sides.
    // Each phase ends with the sender paused until every result is out.
    for (ph = 0; ph < 4; ph++) begin
      cfg_write(ph % 2 == 0);
      cfg_read_check(ph % 2 == 0);
      send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 8 : 0;
      if (ph == 0) hold_go = 1'b1;
      goal = sent_words + PHASE_WORDS;
      while (sent_words < goal) send_word(random_word(), 1'b0, 1'b0, none);
      drain_results();
    end

    $display("Sent %0d input words (%0d more ignored with no page open) over four idle mixes.",
             sent_words, ignored_words);
    $display("Checked %0d free blocks, %0d finalize requests and %0d page summaries.",
             kind_tally[KIND_FREE], kind_tally[KIND_FINALIZE], kind_tally[KIND_SUMMARY]);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
